// ===== design/swmf_pkg.sv =====
// Shared constants and types for the sliding-window maximum filter.
package swmf_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_W            = 7;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic adv;      // an item is taken this cycle
        logic restart;  // that item opens a new sequence
    } cell_ctrl_t;

endpackage

// ===== design/sliding_window_max_filter.sv =====
// Top level of the streaming sliding-window maximum filter.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-------------------------
//  sample in | sample_valid / sample_stall        | sample, start_req
//  max out   | max_valid / max_stall              | window_max
//  config    | window_size_wr_en (no wait)        | window_size
//
// One item per clock unless stalled. A result is registered in the cell chain,
// then moves to the output register and sits there until taken. The cell chain
// is the only state per sample: cell i keeps the max of the last i+1 samples,
// so every window size is ready at once and the output selects window_size-1.
// Reset clears fill count, pending flag and output valid; cell contents are
// not reset and are never read before the current sequence has filled them.
// sample_stall rises only while a result is pending in the chain and the
// output register is full and stalled.
module sliding_window_max_filter #(
    parameter int MAX_WINDOW   = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           window_size_wr_en,
    input  logic [swmf_pkg::CFG_W-1:0]     window_size,
    // sample channel
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           start_req,
    // result channel
    output logic                           max_valid,
    input  logic                           max_stall,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);
    import swmf_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // window size register
    logic [CFG_W-1:0] win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= CFG_W'(1);
        end
        else if (window_size_wr_en)
        begin
            win_reg <= window_size;
        end
    end

    // effective window: zero acts as one, clamp to the chain length
    logic [EXT_W-1:0] win_ext;
    logic [EXT_W-1:0] k_eff;

    always_comb
    begin
        win_ext = EXT_W'(win_reg);
        if (win_ext == '0)
        begin
            k_eff = EXT_W'(1);
        end
        else if (win_ext > EXT_W'(MAX_WINDOW))
        begin
            k_eff = EXT_W'(MAX_WINDOW);
        end
        else
        begin
            k_eff = win_ext;
        end
    end

    // handshake
    logic       accept;
    logic       out_load;
    logic       pend_reg;
    logic       pend_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign out_load     = pend_reg && (!out_valid_reg || !max_stall);
    assign sample_stall = pend_reg && out_valid_reg && max_stall;
    assign accept       = sample_valid && !sample_stall;

    // fill count, saturating at the chain length
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] fill_base;

    always_comb
    begin
        fill_base = start_req ? '0 : fill_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            if (fill_base < CNT_W'(MAX_WINDOW))
            begin
                fill_next = fill_base + CNT_W'(1);
            end
            else
            begin
                fill_next = fill_base;
            end
        end
    end

    // tap to read for the item just taken
    logic [IDX_W-1:0] tap_reg;
    logic [IDX_W-1:0] tap_next;
    logic [EXT_W-1:0] k_minus1;

    assign k_minus1 = k_eff - EXT_W'(1);

    always_comb
    begin
        pend_next = pend_reg;
        tap_next  = tap_reg;
        if (accept)
        begin
            pend_next = (EXT_W'(fill_next) >= k_eff);
            tap_next  = k_minus1[IDX_W-1:0];
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!max_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // cell chain: each cell takes the new sample and its upstream neighbor's max
    cell_ctrl_t                     ctrl;
    logic signed [SAMPLE_WIDTH-1:0] cell_max [MAX_WINDOW];

    assign ctrl.adv     = accept;
    assign ctrl.restart = start_req;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] nbr;
        if (i == 0)
        begin : g_head
            assign nbr = sample;
        end
        else
        begin : g_body
            assign nbr = cell_max[i-1];
        end

        swmf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .sample  (sample),
            .nbr_max (nbr),
            .run_max (cell_max[i])
        );
    end

    // select the window's cell into the output register
    logic signed [SAMPLE_WIDTH-1:0] sel_max;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;

    swmf_tap_sel #(
        .NUM          (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IDX_W        (IDX_W)
    ) u_tap_sel (
        .taps (cell_max),
        .sel  (tap_reg),
        .data (sel_max)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            max_reg <= sel_max;
        end
    end

    assign max_valid  = out_valid_reg;
    assign window_max = max_reg;

endmodule

// ===== design/swmf_cell.sv =====
// One cell of the running-maximum chain: holds max of the last (position+1) samples.
module swmf_cell #(
    parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  swmf_pkg::cell_ctrl_t           ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] nbr_max,
    output logic signed [SAMPLE_WIDTH-1:0] run_max
);
    import swmf_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_next;

    always_comb
    begin
        if (ctrl.restart || (sample > nbr_max))
        begin
            max_next = sample;
        end
        else
        begin
            max_next = nbr_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            max_reg <= max_next;
        end
    end

    assign run_max = max_reg;

endmodule

// ===== design/swmf_tap_sel.sv =====
// Picks one cell of the chain by index (one-hot AND-OR select).
module swmf_tap_sel #(
    parameter int NUM          = swmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swmf_pkg::SAMPLE_WIDTH_DEF,
    parameter int IDX_W        = 6
) (
    input  logic signed [SAMPLE_WIDTH-1:0] taps [NUM],
    input  logic        [IDX_W-1:0]        sel,
    output logic signed [SAMPLE_WIDTH-1:0] data
);
    import swmf_pkg::*;

    always_comb
    begin
        data = '0;
        for (int i = 0; i < NUM; i++)
        begin
            if (sel == IDX_W'(i))
            begin
                data = data | taps[i];
            end
        end
    end

endmodule
